// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the rational arithmetic unit, used by rau_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// label: assert property, disabled during reset
`define RAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// label: assert property, checked during reset too
`define RAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, widths and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned Width = 32;
  // product width plus one carry bit
  localparam int unsigned BigW = 2 * Width + 1;
  localparam int unsigned DivCntW = $clog2(BigW + 1);

  typedef logic [Width-1:0] word_t;
  typedef logic [BigW-1:0] big_t;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpCmp = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StZeroDen = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdMulA,
    CmdMulB,
    CmdPrep,
    CmdGcdStep,
    CmdDivInit,
    CmdDivStep,
    CmdDivNext,
    CmdFinish
  } cmd_e;

  typedef struct packed {
    logic imm_done;
    logic gcd_done;
    logic div_done;
    logic div_last;
    logic k_zero;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, one 32x32 multiplier, binary GCD and a restoring
// divider, all driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  rau_pkg::cmd_e       cmd_i,
  input  wire logic [2:0]     req_type_i,
  input  wire logic           a_negative_i,
  input  rau_pkg::word_t      a_num_i,
  input  rau_pkg::word_t      a_den_i,
  input  wire logic           b_negative_i,
  input  rau_pkg::word_t      b_num_i,
  input  rau_pkg::word_t      b_den_i,
  output rau_pkg::status_t    status_o,
  output logic                res_negative_o,
  output rau_pkg::word_t      res_num_o,
  output rau_pkg::word_t      res_den_o,
  output logic                is_less_o,
  output logic                is_equal_o,
  output logic [1:0]          status_code_o
);
  import rau_pkg::*;

  logic [2:0] op_q;
  logic an_neg_q, bn_neg_q;
  word_t an_q, ad_q, bn_q, bd_q;
  logic [1:0] imm_st_q;
  logic imm_q;
  big_t p0_q, p1_q;            // cross products (numerator product for multiply)
  big_t num_q, den_q;
  logic neg_q;
  big_t ga_q, gb_q;            // gcd operands
  logic [DivCntW-1:0] k_q;
  logic gcd_done_q;
  logic div_sel_q;             // 0 numerator, 1 denominator
  big_t dq_q, dr_q, dn_q;
  logic [DivCntW-1:0] dcnt_q;

  // multiplier inputs by command
  word_t mx, my;
  logic [2*Width-1:0] mp;
  always_comb begin
    mx = an_q;
    my = bd_q;
    unique case (cmd_i)
      CmdMulA: begin
        mx = (op_q == OpMul) ? an_q : an_q;
        my = (op_q == OpMul) ? bn_q : bd_q;
      end
      CmdMulB: begin
        mx = (op_q == OpDiv) ? ad_q : bn_q;
        my = (op_q == OpDiv) ? bn_q : ad_q;
      end
      CmdPrep: begin
        mx = ad_q;
        my = bd_q;
      end
      default: begin
        mx = an_q;
        my = bd_q;
      end
    endcase
  end
  assign mp = mx * my;

  // add/sub combination; multiply and divide pass the first product through
  logic bs;
  big_t comb_num;
  big_t comb_den;
  logic comb_neg;
  always_comb begin
    if (op_q == OpSub) bs = !bn_neg_q && (bn_q != '0);
    else bs = bn_neg_q;
    if (op_q == OpMul || op_q == OpDiv) begin
      comb_num = p0_q;
      comb_neg = an_neg_q ^ bn_neg_q;
    end else if (an_neg_q == bs) begin
      comb_num = p0_q + p1_q;
      comb_neg = an_neg_q;
    end else if (p0_q > p1_q) begin
      comb_num = p0_q - p1_q;
      comb_neg = an_neg_q;
    end else begin
      comb_num = p1_q - p0_q;
      comb_neg = bs;
    end
  end
  assign comb_den = (op_q == OpDiv) ? p1_q : BigW'(mp);

  // gcd step
  big_t gdiff;
  assign gdiff = gb_q - ga_q;

  // divider step
  big_t drs, dsub, dsrc;
  assign dsrc = div_sel_q ? den_q : num_q;
  assign drs = {dr_q[BigW-2:0], dn_q[BigW-1]};
  assign dsub = drs - ga_q;

  logic fits;
  assign fits = (dq_q[BigW-1:Width] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OpAdd;
      an_neg_q <= 1'b0;
      bn_neg_q <= 1'b0;
      an_q <= '0;
      ad_q <= '0;
      bn_q <= '0;
      bd_q <= '0;
      imm_st_q <= StOk;
      p0_q <= '0;
      p1_q <= '0;
      num_q <= '0;
      den_q <= '0;
      neg_q <= 1'b0;
      ga_q <= '0;
      gb_q <= '0;
      k_q <= '0;
      dq_q <= '0;
      dr_q <= '0;
      dn_q <= '0;
      dcnt_q <= '0;
      imm_q <= 1'b0;
      gcd_done_q <= 1'b0;
      res_negative_o <= 1'b0;
      res_num_o <= '0;
      res_den_o <= '0;
      is_less_o <= 1'b0;
      is_equal_o <= 1'b0;
      status_code_o <= StOk;
    end else begin
      unique case (cmd_i)
        CmdLoad: begin
          op_q <= req_type_i;
          an_q <= a_num_i;
          ad_q <= a_den_i;
          bn_q <= b_num_i;
          bd_q <= b_den_i;
          an_neg_q <= a_negative_i && (a_num_i != '0);
          bn_neg_q <= b_negative_i && (b_num_i != '0);
          gcd_done_q <= 1'b0;
          res_negative_o <= 1'b0;
          res_num_o <= '0;
          res_den_o <= '0;
          is_less_o <= 1'b0;
          is_equal_o <= 1'b0;
          if (req_type_i > OpCmp) begin
            imm_q <= 1'b1;
            imm_st_q <= StOk;
          end else if (a_den_i == '0 || b_den_i == '0) begin
            imm_q <= 1'b1;
            imm_st_q <= StZeroDen;
          end else if (req_type_i == OpDiv && b_num_i == '0) begin
            imm_q <= 1'b1;
            imm_st_q <= StDivZero;
          end else begin
            imm_q <= 1'b0;
            imm_st_q <= StOk;
          end
        end
        CmdMulA: p0_q <= BigW'(mp);
        CmdMulB: begin
          p1_q <= BigW'(mp);
          if (op_q == OpCmp) begin
            imm_q <= 1'b1;
            imm_st_q <= StOk;
          end
        end
        CmdPrep: begin
          k_q <= '0;
          if (op_q == OpCmp) begin
            if (an_neg_q != bn_neg_q) begin
              is_less_o <= an_neg_q;
            end else begin
              is_equal_o <= (p0_q == p1_q);
              is_less_o <= an_neg_q ? (p0_q > p1_q) : (p0_q < p1_q);
            end
          end else if (comb_num == '0) begin
            num_q <= '0;
            den_q <= BigW'(1);
            neg_q <= 1'b0;
            ga_q <= BigW'(1);
            gb_q <= BigW'(1);
            gcd_done_q <= 1'b1;
          end else begin
            den_q <= comb_den;
            num_q <= comb_num;
            neg_q <= comb_neg;
            ga_q <= comb_num;
            gb_q <= comb_den;
          end
        end
        CmdGcdStep: begin
          // binary gcd as one state step per cycle
          if (!ga_q[0] && !gb_q[0]) begin
            ga_q <= ga_q >> 1;
            gb_q <= gb_q >> 1;
            k_q <= k_q + DivCntW'(1);
          end else if (!ga_q[0]) begin
            ga_q <= ga_q >> 1;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q > gb_q) begin
            ga_q <= gb_q;
            gb_q <= ga_q - gb_q;
            if (ga_q - gb_q == '0) gcd_done_q <= 1'b1;
          end else begin
            gb_q <= gdiff;
            if (gdiff == '0) gcd_done_q <= 1'b1;
          end
        end
        CmdDivInit: begin
          // restore common power of two into the gcd, then set up the divider
          if (k_q != '0) begin
            ga_q <= ga_q << 1;
            k_q <= k_q - DivCntW'(1);
          end else begin
            dn_q <= dsrc;
            dr_q <= '0;
            dq_q <= '0;
            dcnt_q <= '0;
          end
        end
        CmdDivStep: begin
          dn_q <= dn_q << 1;
          dcnt_q <= dcnt_q + DivCntW'(1);
          if (drs >= ga_q) begin
            dr_q <= dsub;
            dq_q <= {dq_q[BigW-2:0], 1'b1};
          end else begin
            dr_q <= drs;
            dq_q <= {dq_q[BigW-2:0], 1'b0};
          end
        end
        CmdDivNext: begin
          if (!div_sel_q) begin
            res_num_o <= dq_q[Width-1:0];
            if (!fits) imm_st_q <= StOverflow;
          end else begin
            res_den_o <= dq_q[Width-1:0];
            if (!fits) imm_st_q <= StOverflow;
          end
        end
        CmdFinish: begin
          if (imm_q) begin
            status_code_o <= imm_st_q;
          end else if (imm_st_q == StOverflow) begin
            status_code_o <= StOverflow;
            res_num_o <= '0;
            res_den_o <= '0;
            res_negative_o <= 1'b0;
          end else begin
            status_code_o <= StOk;
            res_negative_o <= neg_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_sel_q <= 1'b0;
    end else if (cmd_i == CmdLoad) begin
      div_sel_q <= 1'b0;
    end else if (cmd_i == CmdDivNext) begin
      div_sel_q <= 1'b1;
    end
  end

  assign status_o.imm_done = imm_q;
  assign status_o.gcd_done = gcd_done_q;
  assign status_o.div_done = (dcnt_q == DivCntW'(BigW - 1));
  assign status_o.div_last = div_sel_q;
  assign status_o.k_zero = (k_q == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: accepts a transaction, steps the datapath, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  rau_pkg::status_t   status_i,
  output rau_pkg::cmd_e      cmd_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SMulA, SMulB, SPrep, SGcd, SShift, SDiv, SNext, SFin, SOut
  } state_e;

  state_e state_q;

  always_comb begin
    unique case (state_q)
      SIdle:  cmd_o = (in_valid_i) ? CmdLoad : CmdNone;
      SMulA:  cmd_o = status_i.imm_done ? CmdNone : CmdMulA;
      SMulB:  cmd_o = CmdMulB;
      SPrep:  cmd_o = CmdPrep;
      SGcd:   cmd_o = CmdGcdStep;
      SShift: cmd_o = CmdDivInit;
      SDiv:   cmd_o = CmdDivStep;
      SNext:  cmd_o = CmdDivNext;
      SFin:   cmd_o = CmdFinish;
      default: cmd_o = CmdNone;
    endcase
  end

  assign in_ready_o = (state_q == SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) state_q <= SMulA;
        SMulA: state_q <= status_i.imm_done ? SFin : SMulB;
        SMulB: state_q <= SPrep;
        SPrep: state_q <= status_i.imm_done ? SFin : SGcd;
        SGcd: if (status_i.gcd_done) state_q <= SShift;
        SShift: if (status_i.k_zero) state_q <= SDiv;
        SDiv: if (status_i.div_done) state_q <= SNext;
        SNext: state_q <= status_i.div_last ? SFin : SShift;
        SFin: begin
          state_q <= SOut;
          out_valid_o <= 1'b1;
        end
        SOut: if (out_ready_i) begin
          state_q <= SIdle;
          out_valid_o <= 1'b0;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `include "assert_macros.svh"
  `RAU_ASSERT(a_ready_idle, in_ready_o |-> !out_valid_o, "ready while result pending")
  `RAU_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
  `RAU_ASSERT(a_accept_start, (in_valid_i && in_ready_o) |=> !in_ready_o, "accept did not start")

endmodule

`default_nettype wire

// ----- hw/rtl/rational_arith_unit_top.sv -----
// Sequence: after accept, errors and unknown operations go straight to the
// finish; compare runs the cross multiplies first; arithmetic runs the
// multiplies, the GCD loop, power-of-two restore shifts, then two
// 65-step divisions. Throughput: one transaction at a time; the next is
// accepted only after the result is taken and the sequencer is idle again.
// Reset: asynchronous active low; returns to idle, no result pending.
`default_nettype none

module rational_arith_unit_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic        a_negative_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic        b_negative_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             res_negative_o,
  output logic [31:0]      res_num_o,
  output logic [31:0]      res_den_o,
  output logic             is_less_o,
  output logic             is_equal_o,
  output logic [1:0]       status_o
);
  import rau_pkg::*;

  cmd_e cmd;
  status_t st;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(st), .cmd_o(cmd)
  );

  rau_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_type_i, .a_negative_i, .a_num_i,
    .a_den_i, .b_negative_i, .b_num_i, .b_den_i, .status_o(st),
    .res_negative_o, .res_num_o, .res_den_o, .is_less_o, .is_equal_o,
    .status_code_o(status_o)
  );

endmodule

`default_nettype wire

// ----- sim/tb_rational_arith_unit_top.sv -----
// ----------------------------------------------------------------------------
// tb_rational_arith_unit_top
// Drives random and corner-case fraction operations through the rational
// arithmetic unit and checks every result against an exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_rational_arith_unit_top;
  import rau_pkg::*;

  typedef logic [129:0] wide_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        a_neg;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic        b_neg;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } frac_req_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] num;
    logic [31:0] den;
    logic        less;
    logic        equal;
    logic [1:0]  status;
  } frac_res_t;

  function automatic wide_t gcd_of(wide_t x, wide_t y);
    wide_t t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t predict_fraction(frac_req_t q);
    frac_res_t r;
    logic an, bn, bs, neg;
    wide_t l, rr, num, den, g;
    r = '0;
    an = q.a_neg && (q.a_num != 0);
    bn = q.b_neg && (q.b_num != 0);
    if (q.op > OpCmp) return r;
    if (q.a_den == 0 || q.b_den == 0) begin
      r.status = StZeroDen;
      return r;
    end
    if (q.op == OpDiv && q.b_num == 0) begin
      r.status = StDivZero;
      return r;
    end
    l = wide_t'(q.a_num) * wide_t'(q.b_den);
    rr = wide_t'(q.b_num) * wide_t'(q.a_den);
    if (q.op == OpCmp) begin
      if (an != bn) begin
        r.less = an;
      end else begin
        r.equal = (l == rr);
        r.less = an ? (l > rr) : (l < rr);
      end
      return r;
    end
    den = wide_t'(q.a_den) * wide_t'(q.b_den);
    if (q.op == OpAdd || q.op == OpSub) begin
      bs = (q.op == OpSub) ? (!bn && q.b_num != 0) : bn;
      if (an == bs) begin
        num = l + rr;
        neg = an;
      end else if (l > rr) begin
        num = l - rr;
        neg = an;
      end else begin
        num = rr - l;
        neg = bs;
      end
    end else if (q.op == OpMul) begin
      num = wide_t'(q.a_num) * wide_t'(q.b_num);
      neg = an ^ bn;
    end else begin
      num = l;
      den = wide_t'(q.a_den) * wide_t'(q.b_num);
      neg = an ^ bn;
    end
    if (num == 0) begin
      den = 1;
      neg = 1'b0;
    end else begin
      g = gcd_of(num, den);
      num = num / g;
      den = den / g;
    end
    if (num[129:32] != 0 || den[129:32] != 0) begin
      r.status = StOverflow;
    end else begin
      r.neg = neg;
      r.num = num[31:0];
      r.den = den[31:0];
    end
    return r;
  endfunction

  class fraction_scoreboard;
    frac_res_t pending[$];
    int errors;

    function void note_request(frac_req_t q);
      pending.push_back(predict_fraction(q));
    endfunction

    function void check_result(frac_res_t got);
      frac_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.neg !== e.neg) begin
        $error("res_negative exp %0d got %0d", e.neg, got.neg); errors++;
      end
      if (got.num !== e.num) begin
        $error("res_num exp %0d got %0d", e.num, got.num); errors++;
      end
      if (got.den !== e.den) begin
        $error("res_den exp %0d got %0d", e.den, got.den); errors++;
      end
      if (got.less !== e.less) begin
        $error("is_less exp %0d got %0d", e.less, got.less); errors++;
      end
      if (got.equal !== e.equal) begin
        $error("is_equal exp %0d got %0d", e.equal, got.equal); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, in_valid_i, out_ready_i, in_ready_o, out_valid_o;
  frac_req_t req;
  logic res_negative_o, is_less_o, is_equal_o;
  logic [31:0] res_num_o, res_den_o;
  logic [1:0] status_o;
  logic calm;
  fraction_scoreboard sb;

  rational_arith_unit_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .req_type_i(req.op), .a_negative_i(req.a_neg), .a_num_i(req.a_num),
    .a_den_i(req.a_den), .b_negative_i(req.b_neg), .b_num_i(req.b_num),
    .b_den_i(req.b_den), .out_valid_o, .out_ready_i,
    .res_negative_o, .res_num_o, .res_den_o, .is_less_o, .is_equal_o, .status_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(1, 16);
      4: return $urandom_range(1, 1000);
      5: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(frac_req_t q);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req <= q;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(q);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [2:0] op, logic an, logic [31:0] anu, logic [31:0] ad,
                             logic bn, logic [31:0] bnu, logic [31:0] bd);
    frac_req_t q;
    q = '{op, an, anu, ad, bn, bnu, bd};
    send_request(q);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{res_negative_o, res_num_o, res_den_o, is_less_o, is_equal_o,
                        status_o});
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 23);
  end

  initial begin
    frac_req_t q;
    int wait_cnt;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    calm = 1'b0;
    req = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed corners
    send_fields(OpAdd, 0, 1, 2, 0, 1, 3);
    send_fields(OpSub, 0, 1, 2, 0, 1, 2);
    send_fields(OpSub, 1, 1, 3, 0, 1, 2);
    send_fields(OpAdd, 1, 0, 5, 1, 0, 7);
    send_fields(OpMul, 1, 2, 3, 0, 3, 4);
    send_fields(OpDiv, 1, 2, 3, 1, 4, 9);
    send_fields(OpDiv, 0, 1, 2, 1, 0, 3);
    send_fields(OpAdd, 0, 1, 0, 0, 1, 2);
    send_fields(OpCmp, 0, 1, 2, 0, 1, 0);
    send_fields(OpCmp, 1, 1, 2, 1, 1, 3);
    send_fields(OpCmp, 1, 2, 4, 1, 1, 2);
    send_fields(OpCmp, 0, 1, 3, 1, 1, 2);
    send_fields(OpCmp, 1, 0, 3, 0, 0, 2);
    send_fields(OpMul, 0, '1, 1, 0, '1, 1);
    send_fields(OpAdd, 1, '1, '1, 1, '1, '1);
    send_fields(OpSub, 0, '1, 1, 1, '1, 1);
    send_fields(OpDiv, 0, '1, 1, 0, 1, '1);
    send_fields(3'd5, 1, 7, 3, 1, 5, 2);
    send_fields(3'd7, 1, '1, '1, 1, '1, '1);
    send_fields(3'd6, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 1250; i++) begin
      calm = (i >= 500 && i < 650);
      q.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      q.a_neg = 1'($urandom_range(0, 1));
      q.b_neg = 1'($urandom_range(0, 1));
      q.a_num = pick_word();
      q.b_num = pick_word();
      q.a_den = pick_word();
      q.b_den = pick_word();
      if ($urandom_range(0, 9) != 0 && q.a_den == 0) q.a_den = 1;
      if ($urandom_range(0, 9) != 0 && q.b_den == 0) q.b_den = 1;
      send_request(q);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 100_000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

`default_nettype wire
